FILE: src/rsenc_pkg.sv
// shared types, constants and field arithmetic for the reed-solomon encoder
`timescale 1ns / 1ps

package rsenc_pkg;

    // largest generator degree held by the cell row
    localparam int MAX_EC   = 32;
    // parity count selected after reset
    localparam int EC_RESET = 7;
    // width of the parity count register
    localparam int EC_W     = 6;
    // index into the cell row
    localparam int IDX_W    = (MAX_EC > 1) ? $clog2(MAX_EC) : 1;
    // codeword width
    localparam int SYM_W    = 8;
    // field polynomial x^8+x^4+x^3+x^2+1
    localparam logic [SYM_W:0] FIELD_POLY = 9'h11d;

    // register indexes
    localparam logic REG_EC_COUNT = 1'b0;

    // sequencer states
    typedef enum logic [1:0] {
        ST_INIT,
        ST_BUILD,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // controls fanned out to every cell of the row
    typedef struct packed {
        logic             init;
        logic             step;
        logic             build;
        logic [SYM_W-1:0] mul_a;
    } cell_ctrl_t;

    // one output beat
    typedef struct packed {
        logic [SYM_W-1:0] code;
        logic             parity;
        logic             last;
    } beat_t;

    // gf(256) multiply, shift and add over eight partial products
    function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b);
        logic [SYM_W:0]   x;
        logic [SYM_W-1:0] acc;
        x   = {1'b0, a};
        acc = '0;
        for (int k = 0; k < SYM_W; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x[SYM_W-1:0];
            end
            x = {x[SYM_W-1:0], 1'b0};
            if (x[SYM_W])
            begin
                x = x ^ FIELD_POLY;
            end
        end
        return acc;
    endfunction

endpackage

FILE: src/qr_reed_solomon_encoder_unit.sv
// top level of the qr reed-solomon encoder: sequencer, cell row and output queue
`timescale 1ns / 1ps
//
// Systematic RS encoder over GF(256), polynomial 0x11d, generator roots
// alpha^0 .. alpha^(ec_count-1). Data codewords enter on the in channel
// (in_valid/in_stall, data_byte, last_data), one beat per cycle while
// in_stall is low, and each is echoed on the out channel through the output queue.
// After the beat marked last_data, ec_count parity beats follow, one per
// cycle while the output queue is not full, highest coefficient first; the
// final one carries last_out. The input stalls while they are sent.
// A row of MAX_EC cells holds the remainder taps and generator
// coefficients; every tap updates in parallel on each data beat.
// ec_count (apb register 0) is clamped to MAX_EC. A write restarts the
// block and rebuilds the generator in the cell row while in_stall stays
// high. After reset the same rebuild runs for ec_count = 7.
// A stalled receiver fills the two-entry output queue and then holds
// in_stall high; no beat is lost and the cell row waits.
//
module qr_reed_solomon_encoder_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rsenc_pkg::SYM_W-1:0]   data_byte,
    input  logic                          last_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rsenc_pkg::SYM_W-1:0]   code_byte,
    output logic                          is_parity,
    output logic                          last_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rsenc_pkg::*;

    state_t            state_reg, state_next;
    logic [EC_W-1:0]   ec_reg, ec_next;
    logic [IDX_W-1:0]  build_cnt_reg, build_cnt_next;
    logic [EC_W-1:0]   drain_cnt_reg, drain_cnt_next;
    logic [SYM_W-1:0]  root_reg, root_next;

    logic              cfg_wr;
    logic [EC_W-1:0]   cfg_ec;
    logic              in_acc;
    logic              fifo_full;
    logic              push;
    beat_t             push_beat;
    beat_t             out_beat;
    cell_ctrl_t        ctrl;
    logic [EC_W-1:0]   ec_m1;
    logic [IDX_W-1:0]  top_idx;
    logic [SYM_W-1:0]  top_rem;
    logic [SYM_W-1:0]  rem [MAX_EC];
    logic [SYM_W-1:0]  gen [MAX_EC];

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EC_COUNT);
    assign cfg_ec = (pwdata[EC_W-1:0] > EC_W'(MAX_EC)) ? EC_W'(MAX_EC) : pwdata[EC_W-1:0];
    assign prdata = (paddr[2] == REG_EC_COUNT) ? {{(32-EC_W){1'b0}}, ec_reg} : 32'd0;

    // highest remainder tap for the current degree
    assign ec_m1   = ec_reg - 1'b1;
    assign top_idx = ec_m1[IDX_W-1:0];
    assign top_rem = rem[top_idx];

    assign in_stall = (state_reg != ST_RUN) || fifo_full;
    assign in_acc   = in_valid && !in_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                state_next = (ec_reg == '0) ? ST_RUN : ST_BUILD;
            end
            ST_BUILD:
            begin
                if (build_cnt_reg == top_idx)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (in_acc && last_data && (ec_reg != '0))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!fifo_full && (drain_cnt_reg == EC_W'(1)))
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
        if (cfg_wr)
        begin
            state_next = ST_INIT;
        end
    end

    // outputs of the sequencer: cell controls, queue push and counters
    always_comb
    begin
        ctrl           = '0;
        push           = 1'b0;
        push_beat      = '0;
        build_cnt_next = build_cnt_reg;
        drain_cnt_next = drain_cnt_reg;
        root_next      = root_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                ctrl.init      = 1'b1;
                build_cnt_next = '0;
                root_next      = SYM_W'(1);
            end
            ST_BUILD:
            begin
                ctrl.build     = 1'b1;
                ctrl.mul_a     = root_reg;
                build_cnt_next = build_cnt_reg + 1'b1;
                root_next      = gf_mul(root_reg, SYM_W'(2));
            end
            ST_RUN:
            begin
                if (in_acc)
                begin
                    ctrl.step        = (ec_reg != '0);
                    ctrl.mul_a       = data_byte ^ top_rem;
                    push             = 1'b1;
                    push_beat.code   = data_byte;
                    push_beat.parity = 1'b0;
                    push_beat.last   = last_data && (ec_reg == '0);
                    drain_cnt_next   = ec_reg;
                end
            end
            ST_DRAIN:
            begin
                if (!fifo_full)
                begin
                    // zero feedback turns the lfsr step into a shift
                    ctrl.step        = 1'b1;
                    ctrl.mul_a       = '0;
                    push             = 1'b1;
                    push_beat.code   = top_rem;
                    push_beat.parity = 1'b1;
                    push_beat.last   = (drain_cnt_reg == EC_W'(1));
                    drain_cnt_next   = drain_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // parity count register
    always_comb
    begin
        ec_next = cfg_wr ? cfg_ec : ec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ec_reg        <= EC_W'(EC_RESET);
            build_cnt_reg <= '0;
            drain_cnt_reg <= '0;
            root_reg      <= SYM_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            ec_reg        <= ec_next;
            build_cnt_reg <= build_cnt_next;
            drain_cnt_reg <= drain_cnt_next;
            root_reg      <= root_next;
        end
    end

    // row of cells, each fed by its lower neighbor
    for (genvar j = 0; j < MAX_EC; j++)
    begin : g_cell
        logic [SYM_W-1:0] rem_prev;
        logic [SYM_W-1:0] gen_prev;
        logic [SYM_W-1:0] init_coeff;
        if (j == 0)
        begin : g_first
            assign rem_prev   = '0;
            assign gen_prev   = '0;
            assign init_coeff = SYM_W'(1);
        end
        else
        begin : g_rest
            assign rem_prev   = rem[j-1];
            assign gen_prev   = gen[j-1];
            assign init_coeff = '0;
        end
        rsenc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .init_coeff (init_coeff),
            .rem_prev   (rem_prev),
            .gen_prev   (gen_prev),
            .rem        (rem[j]),
            .gen        (gen[j])
        );
    end

    // output queue
    rsenc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    assign code_byte = out_beat.code;
    assign is_parity = out_beat.parity;
    assign last_out  = out_beat.last;

`ifndef SYNTHESIS
    // a last data beat with parity enabled starts the parity run unless a register write intervenes
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last_data && (ec_reg != '0) && !cfg_wr) |=> (state_reg == ST_DRAIN))
        else $error("parity run not started after last data beat");

    // the parity run never counts past zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (drain_cnt_reg != '0))
        else $error("parity counter empty during parity run");

    // the generator build stops at the programmed degree
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> (EC_W'(build_cnt_reg) < ec_reg))
        else $error("generator build overran its degree");

    // the parity beat that ends a block closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_beat.parity && push_beat.last && !cfg_wr) |=> (state_reg == ST_RUN))
        else $error("parity run did not end on the last parity beat");
`endif

endmodule

FILE: src/rsenc_cell.sv
// one cell of the encoder row: a remainder tap and a generator coefficient
`timescale 1ns / 1ps

module rsenc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rsenc_pkg::cell_ctrl_t     ctrl,
    input  logic [rsenc_pkg::SYM_W-1:0] init_coeff,
    input  logic [rsenc_pkg::SYM_W-1:0] rem_prev,
    input  logic [rsenc_pkg::SYM_W-1:0] gen_prev,
    output logic [rsenc_pkg::SYM_W-1:0] rem,
    output logic [rsenc_pkg::SYM_W-1:0] gen
);
    import rsenc_pkg::*;

    logic [SYM_W-1:0] rem_reg, rem_next;
    logic [SYM_W-1:0] gen_reg, gen_next;
    logic [SYM_W-1:0] prod;

    // shared multiplier: feedback times coefficient, or coefficient times root
    assign prod = gf_mul(ctrl.mul_a, gen_reg);

    // remainder tap: cleared on init, lfsr step (plain shift when feedback is zero), else held
    always_comb
    begin
        priority if (ctrl.init)
        begin
            rem_next = '0;
        end
        else if (ctrl.step)
        begin
            rem_next = rem_prev ^ prod;
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    // generator coefficient: loaded on init, else multiply running product by (x + root) on build
    always_comb
    begin
        priority if (ctrl.init)
        begin
            gen_next = init_coeff;
        end
        else if (ctrl.build)
        begin
            gen_next = gen_prev ^ prod;
        end
        else
        begin
            gen_next = gen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            gen_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            gen_reg <= gen_next;
        end
    end

    assign rem = rem_reg;
    assign gen = gen_reg;

endmodule

FILE: src/rsenc_out_fifo.sv
// two-entry output queue that decouples the cell row from the receiver
`timescale 1ns / 1ps

module rsenc_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rsenc_pkg::beat_t      push_beat,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rsenc_pkg::beat_t      out_beat
);
    import rsenc_pkg::*;

    beat_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_beat  = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // beat storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule
